// File: rtl/core/complex_arithmetic_unit_defines.svh
// Assertion macros shared by the complex arithmetic unit RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define CAU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define CAU_NEVER(name, cond, msg) \
  `CAU_ASSERT(name, !(cond), msg)

`endif

// File: rtl/core/cau_pkg.sv
// Package for the complex arithmetic unit: operation and status codes.
// No dependencies.
`timescale 1ns / 1ps

package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

endpackage

// File: rtl/core/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: add, subtract, multiply and divide on
// signed fixed-point complex operands. Uses cau_pkg and cau_div_cell.
`timescale 1ns / 1ps
// Usage:
// An item is an operation code and two complex operands a and b, each part a
// signed fixed-point number. It is accepted at a rising edge with start_i high
// and busy_o low. busy_o is always low, so an item can be accepted every cycle.
// Each item gives exactly one result on res_re_o, res_im_o and status_o, marked
// by valid_o for one cycle; the receiver cannot stall, and none is needed since
// the pipeline never holds results back.
// Every operation takes the same path from the accepting edge to the edge at
// which the result is taken: one stage forms all the products, one stage sums
// them and prepares the quotients, then a row of WORD_BITS + 1 divider cells
// gives one quotient bit each, and a final stage saturates and registers the
// result. Throughput is one item per cycle.
// Add, subtract and multiply results travel alongside the divider row so items
// leave in the order in which they came.
// Status is 0 when fine, 1 when a part saturated, 2 for a zero divisor (the
// result is then zero). Reset clears the valid pipeline, so no result appears
// for an item that was not accepted after reset.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  op_i,
  input  logic signed [WORD_BITS-1:0] a_re_i,
  input  logic signed [WORD_BITS-1:0] a_im_i,
  input  logic signed [WORD_BITS-1:0] b_re_i,
  input  logic signed [WORD_BITS-1:0] b_im_i,
  output logic                        valid_o,
  output logic signed [WORD_BITS-1:0] res_re_o,
  output logic signed [WORD_BITS-1:0] res_im_o,
  output logic [1:0]                  status_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int XW = PW + 1;
  localparam int QB = W + 1;
  localparam int DW = PW + F;
  localparam int Lat = QB + 3;

  localparam logic signed [XW-1:0] WmaxX = XW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] WminX = -WmaxX - XW'(1);
  localparam logic [W-1:0]  WmaxW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WminW = {1'b1, {(W-1){1'b0}}};
  localparam logic [QB-1:0] HalfQ = QB'(1) << (W - 1);
  localparam logic [QB-1:0] WmaxQ = HalfQ - QB'(1);

  typedef struct packed {
    logic         is_div;
    logic         div_zero;
    logic         neg_re;
    logic         neg_im;
    logic         ovf_re;
    logic         ovf_im;
    logic [W-1:0] byp_re;
    logic [W-1:0] byp_im;
    logic [1:0]   byp_st;
  } side_t;

  // Stage 1: products and add/subtract sums.
  logic                 v1_q;
  logic [1:0]           op1_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bbr_q, p_bbi_q;
  logic signed [W:0]    as_re_q, as_im_q;
  logic signed [W:0]    as_re_d, as_im_d;

  assign busy_o = 1'b0;

  always_comb begin
    if (op_i == OP_SUB) begin
      as_re_d = (W+1)'(a_re_i) - (W+1)'(b_re_i);
      as_im_d = (W+1)'(a_im_i) - (W+1)'(b_im_i);
    end else begin
      as_re_d = (W+1)'(a_re_i) + (W+1)'(b_re_i);
      as_im_d = (W+1)'(a_im_i) + (W+1)'(b_im_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q   <= op_i;
    p_rr_q  <= a_re_i * b_re_i;
    p_ii_q  <= a_im_i * b_im_i;
    p_ri_q  <= a_re_i * b_im_i;
    p_ir_q  <= a_im_i * b_re_i;
    p_bbr_q <= b_re_i * b_re_i;
    p_bbi_q <= b_im_i * b_im_i;
    as_re_q <= as_re_d;
    as_im_q <= as_im_d;
  end

  // Stage 2: sum products, saturate the direct results, prepare the dividends.
  logic signed [XW-1:0] x_re, x_im, num_re, num_im, mag_re_x, mag_im_x;
  logic [PW-1:0]        den;
  logic [DW-1:0]        dd_re, dd_im, hi_re, hi_im;
  logic                 sat_re2, sat_im2;
  side_t                side_d;

  assign num_re   = XW'(p_rr_q) + XW'(p_ii_q);
  assign num_im   = XW'(p_ir_q) - XW'(p_ri_q);
  assign mag_re_x = num_re[XW-1] ? -num_re : num_re;
  assign mag_im_x = num_im[XW-1] ? -num_im : num_im;
  assign den      = $unsigned(p_bbr_q) + $unsigned(p_bbi_q);
  assign dd_re    = DW'(mag_re_x[PW-1:0]) << F;
  assign dd_im    = DW'(mag_im_x[PW-1:0]) << F;
  assign hi_re    = dd_re >> QB;
  assign hi_im    = dd_im >> QB;

  always_comb begin
    if (op1_q == OP_MUL) begin
      x_re = (XW'(p_rr_q) - XW'(p_ii_q)) >>> F;
      x_im = (XW'(p_ri_q) + XW'(p_ir_q)) >>> F;
    end else begin
      x_re = XW'(as_re_q);
      x_im = XW'(as_im_q);
    end
    sat_re2         = (x_re > WmaxX) || (x_re < WminX);
    sat_im2         = (x_im > WmaxX) || (x_im < WminX);
    side_d.is_div   = op1_q == OP_DIV;
    side_d.div_zero = den == '0;
    side_d.neg_re   = num_re[XW-1];
    side_d.neg_im   = num_im[XW-1];
    side_d.ovf_re   = hi_re >= DW'(den);
    side_d.ovf_im   = hi_im >= DW'(den);
    side_d.byp_re   = sat_re2 ? (x_re[XW-1] ? WminW : WmaxW) : x_re[W-1:0];
    side_d.byp_im   = sat_im2 ? (x_im[XW-1] ? WminW : WmaxW) : x_im[W-1:0];
    side_d.byp_st   = (sat_re2 || sat_im2) ? ST_SAT : ST_OK;
  end

  // Divider row: index 0 is stage 2, index QB is the row output.
  logic  [QB:0]   vld_q;
  side_t          side_q [QB+1];
  logic [PW-1:0]  den_re [QB+1], den_im [QB+1];
  logic [PW-1:0]  rem_re [QB+1], rem_im [QB+1];
  logic [QB-1:0]  dlo_re [QB+1], dlo_im [QB+1];
  logic [QB-1:0]  quo_re [QB+1], quo_im [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QB-1:0], v1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    den_re[0] <= den;
    den_im[0] <= den;
    rem_re[0] <= hi_re[PW-1:0];
    rem_im[0] <= hi_im[PW-1:0];
    dlo_re[0] <= dd_re[QB-1:0];
    dlo_im[0] <= dd_im[QB-1:0];
    quo_re[0] <= '0;
    quo_im[0] <= '0;
    for (int k = 0; k < QB; k++) begin
      side_q[k+1] <= side_q[k];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_row
    cau_div_cell #(.PW(PW), .QB(QB)) u_cell_re (
      .clk_i (clk_i),
      .den_i (den_re[k]),   .rem_i (rem_re[k]),
      .dlo_i (dlo_re[k]),   .q_i   (quo_re[k]),
      .den_o (den_re[k+1]), .rem_o (rem_re[k+1]),
      .dlo_o (dlo_re[k+1]), .q_o   (quo_re[k+1])
    );
    cau_div_cell #(.PW(PW), .QB(QB)) u_cell_im (
      .clk_i (clk_i),
      .den_i (den_im[k]),   .rem_i (rem_im[k]),
      .dlo_i (dlo_im[k]),   .q_i   (quo_im[k]),
      .den_o (den_im[k+1]), .rem_o (rem_im[k+1]),
      .dlo_o (dlo_im[k+1]), .q_o   (quo_im[k+1])
    );
  end

  // Output stage: sign and saturate the quotients, pick the result.
  side_t         so;
  logic [QB-1:0] qr, qi, nqr, nqi;
  logic          dsat_re, dsat_im;
  logic [W-1:0]  dres_re, dres_im;
  logic [W-1:0]  res_re_d, res_im_d;
  logic [1:0]    status_d;

  assign so  = side_q[QB];
  assign qr  = quo_re[QB];
  assign qi  = quo_im[QB];
  assign nqr = -qr;
  assign nqi = -qi;

  always_comb begin
    if (so.neg_re) begin
      dsat_re = so.ovf_re || (qr > HalfQ);
      dres_re = dsat_re ? WminW : nqr[W-1:0];
    end else begin
      dsat_re = so.ovf_re || (qr > WmaxQ);
      dres_re = dsat_re ? WmaxW : qr[W-1:0];
    end
    if (so.neg_im) begin
      dsat_im = so.ovf_im || (qi > HalfQ);
      dres_im = dsat_im ? WminW : nqi[W-1:0];
    end else begin
      dsat_im = so.ovf_im || (qi > WmaxQ);
      dres_im = dsat_im ? WmaxW : qi[W-1:0];
    end
    if (!so.is_div) begin
      res_re_d = so.byp_re;
      res_im_d = so.byp_im;
      status_d = so.byp_st;
    end else if (so.div_zero) begin
      res_re_d = '0;
      res_im_d = '0;
      status_d = ST_DIVZ;
    end else begin
      res_re_d = dres_re;
      res_im_d = dres_im;
      status_d = (dsat_re || dsat_im) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    res_re_o <= res_re_d;
    res_im_o <= res_im_d;
    status_o <= status_d;
  end

  `CAU_ASSERT(a_latency, start_i && !busy_o |-> ##Lat valid_o, "result missing after fixed latency")
  `CAU_NEVER(a_divz_zero, valid_o && status_o == ST_DIVZ && (res_re_o != '0 || res_im_o != '0), "zero divisor gave a nonzero result")
  `CAU_ASSERT(a_sat_limit, valid_o && status_o == ST_SAT |-> res_re_o == WmaxW || res_re_o == WminW || res_im_o == WmaxW || res_im_o == WminW, "saturation status without a limit value")

endmodule

// File: rtl/core/cau_div_cell.sv
// One cell of the restoring divider row: develops one quotient bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module cau_div_cell #(
  parameter int PW = 32,
  parameter int QB = 17
) (
  input  logic          clk_i,
  input  logic [PW-1:0] den_i,
  input  logic [PW-1:0] rem_i,
  input  logic [QB-1:0] dlo_i,
  input  logic [QB-1:0] q_i,
  output logic [PW-1:0] den_o,
  output logic [PW-1:0] rem_o,
  output logic [QB-1:0] dlo_o,
  output logic [QB-1:0] q_o
);

  logic [PW:0]   shifted;
  logic [PW:0]   diff;
  logic          ge;
  logic [PW-1:0] rem_d;
  logic [QB-1:0] dlo_d;
  logic [QB-1:0] q_d;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_i, dlo_i[QB-1]};
  assign ge      = shifted >= {1'b0, den_i};
  assign diff    = shifted - {1'b0, den_i};
  assign rem_d   = ge ? diff[PW-1:0] : shifted[PW-1:0];
  assign dlo_d   = dlo_i << 1;
  assign q_d     = {q_i[QB-2:0], ge};

  always_ff @(posedge clk_i) begin
    den_o <= den_i;
    rem_o <= rem_d;
    dlo_o <= dlo_d;
    q_o   <= q_d;
  end

endmodule
